// ----- design/rspg_pkg.sv -----
// Package with the shared types and constants of the RGB status pattern generator.
`timescale 1ns / 1ps

package rspg_pkg;

   // Word kinds carried on the request side.
   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_SELECT = 1'b1
   } op_type;

   // Pattern numbers.
   typedef logic [3:0] pattern_type;
   localparam pattern_type PAT_OFF             = 4'd0;
   localparam pattern_type PAT_SOLID_RED       = 4'd1;
   localparam pattern_type PAT_SOLID_GREEN     = 4'd2;
   localparam pattern_type PAT_SOLID_BLUE      = 4'd3;
   localparam pattern_type PAT_SOLID_AMBER     = 4'd4;
   localparam pattern_type PAT_FLASH_GREEN     = 4'd5;
   localparam pattern_type PAT_FLASH_RED_SLOW  = 4'd6;
   localparam pattern_type PAT_FLASH_RED_FAST  = 4'd7;
   localparam pattern_type PAT_FLASH_AMBER     = 4'd8;
   localparam pattern_type PAT_FLASH_AMBER_DBL = 4'd9;
   localparam pattern_type PAT_BREATHE_RED     = 4'd10;
   localparam pattern_type PAT_BREATHE_BLUE    = 4'd11;
   localparam pattern_type PAT_RAINBOW         = 4'd12;
   localparam pattern_type PAT_FLASH_WHITE     = 4'd13;
   localparam pattern_type PAT_SUCCESS         = 4'd14;
   localparam pattern_type PAT_UNUSED          = 4'd15;

   localparam int ELAPSED_W = 32;

   // Phase counter periods.
   localparam int BREATHE_PERIOD = 2000;
   localparam int BREATHE_HALF   = BREATHE_PERIOD / 2;
   localparam int SLOW_PERIOD    = 1000;
   localparam int AMBER_PERIOD   = 500;
   localparam int FAST_PERIOD    = 200;

   localparam int PH2000_W = $clog2(BREATHE_PERIOD);
   localparam int PH1000_W = $clog2(SLOW_PERIOD);
   localparam int PH500_W  = $clog2(AMBER_PERIOD);
   localparam int PH200_W  = $clog2(FAST_PERIOD);

   // Levels.
   localparam logic [7:0] LEVEL_FULL  = 8'd255;
   localparam logic [7:0] AMBER_GREEN = 8'd140;

   // Breathing level is q * 255 / 1000, done as a multiply by a scaled reciprocal.
   localparam int          RECIP_SHIFT = 28;
   localparam logic [26:0] BREATHE_RECIP = 27'd68451180;
   localparam int          PROD_W = PH2000_W + 27;

   // Pattern state passed from the timer to the renderer.
   typedef struct packed {
      pattern_type          pattern;
      logic [ELAPSED_W-1:0] elapsed;
      logic [PH2000_W-1:0]  ph2000;
      logic [PH1000_W-1:0]  ph1000;
      logic [PH500_W-1:0]   ph500;
      logic [PH200_W-1:0]   ph200;
      logic                 finished;
   } timer_state_type;

endpackage

// ----- design/rgb_status_pattern_generator.sv -----
// Top level of the RGB status pattern generator.
`timescale 1ns / 1ps

// RGB status LED pattern generator.
// Request channel: each word is either a one millisecond tick (req_tuser = 0)
// or a pattern select (req_tuser = 1, pattern number in req_tdata[3:0]).
// A tick advances the 32-bit elapsed time, which wraps; a select loads the
// pattern and restarts time at zero. Unknown pattern fifteen behaves as off.
// Response channel: exactly one word per request word, in order, carrying
// the red, green and blue duty levels and the done flag of one-shot patterns.
// From request acceptance to rsp_tvalid, the accepted word sits in the
// input register, the pattern state registers take it from there and
// the result register takes it from them.
// One word per cycle when not stalled; the three stages move together.
// When the receiver stalls with a word waiting, all stages hold and
// req_tready falls in the same cycle, even while bubbles sit in the pipeline.
// Reset (synchronous, active high) selects the off pattern with elapsed time
// zero and done set, and empties the pipeline.
module rgb_status_pattern_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] pattern, [7:4] zero
   input  logic [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] red, [15:8] green, [23:16] blue,
                                    // [24] done_res, [31:25] zero
);
   import rspg_pkg::*;

   logic            advance;
   logic            in_valid_ff;
   logic            in_op_ff;
   pattern_type     in_pattern_ff;
   logic            st_valid_ff;
   logic            done_now;
   timer_state_type state;
   logic [7:0]      red, green, blue;
   logic            done_res;

   // The whole pipeline moves unless a finished word is waiting.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Input register and stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
         st_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         in_op_ff      <= req_tuser[0];
         in_pattern_ff <= req_tdata[3:0];
      end
   end

   rspg_timer u_timer (
      .clock     (clock),
      .reset     (reset),
      .update    (advance && in_valid_ff),
      .operation (in_op_ff),
      .pattern   (in_pattern_ff),
      .done_now  (done_now),
      .state     (state)
   );

   rspg_render u_render (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .state_valid (st_valid_ff),
      .state       (state),
      .done_now    (done_now),
      .rsp_valid   (rsp_tvalid),
      .rsp_red     (red),
      .rsp_green   (green),
      .rsp_blue    (blue),
      .rsp_done    (done_res)
   );

   assign rsp_tdata = {7'd0, done_res, blue, green, red};

endmodule

// ----- design/rspg_timer.sv -----
// Pattern register, elapsed millisecond counter, phase counters and sticky done flag.
`timescale 1ns / 1ps

module rspg_timer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     update,
   input  logic                     operation,
   input  rspg_pkg::pattern_type    pattern,
   input  logic                     done_now,
   output rspg_pkg::timer_state_type state
);
   import rspg_pkg::*;

   pattern_type          pattern_ff, pattern_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [PH2000_W-1:0]  ph2000_ff, ph2000_in;
   logic [PH1000_W-1:0]  ph1000_ff, ph1000_in;
   logic [PH500_W-1:0]   ph500_ff, ph500_in;
   logic [PH200_W-1:0]   ph200_ff, ph200_in;
   logic                 finished_ff, finished_in;
   logic                 wrap;

   // Next state: a select restarts time, a tick advances every counter.
   // The phase counters track elapsed modulo their period, so they restart
   // together with the elapsed counter when it wraps.
   always_comb begin
      wrap        = (elapsed_ff == {ELAPSED_W{1'b1}});
      pattern_in  = pattern_ff;
      elapsed_in  = elapsed_ff;
      ph2000_in   = ph2000_ff;
      ph1000_in   = ph1000_ff;
      ph500_in    = ph500_ff;
      ph200_in    = ph200_ff;
      finished_in = finished_ff;
      if (update) begin
         if (operation == OP_SELECT) begin
            pattern_in  = pattern;
            elapsed_in  = '0;
            ph2000_in   = '0;
            ph1000_in   = '0;
            ph500_in    = '0;
            ph200_in    = '0;
            finished_in = (pattern == PAT_OFF) || (pattern == PAT_UNUSED);
         end else begin
            elapsed_in  = elapsed_ff + 1'b1;
            finished_in = done_now;
            if (wrap) begin
               ph2000_in = '0;
               ph1000_in = '0;
               ph500_in  = '0;
               ph200_in  = '0;
            end else begin
               ph2000_in = (ph2000_ff == PH2000_W'(BREATHE_PERIOD - 1)) ? '0 : ph2000_ff + 1'b1;
               ph1000_in = (ph1000_ff == PH1000_W'(SLOW_PERIOD - 1)) ? '0 : ph1000_ff + 1'b1;
               ph500_in  = (ph500_ff == PH500_W'(AMBER_PERIOD - 1)) ? '0 : ph500_ff + 1'b1;
               ph200_in  = (ph200_ff == PH200_W'(FAST_PERIOD - 1)) ? '0 : ph200_ff + 1'b1;
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= PAT_OFF;
         elapsed_ff  <= '0;
         ph2000_ff   <= '0;
         ph1000_ff   <= '0;
         ph500_ff    <= '0;
         ph200_ff    <= '0;
         finished_ff <= 1'b1;
      end else begin
         pattern_ff  <= pattern_in;
         elapsed_ff  <= elapsed_in;
         ph2000_ff   <= ph2000_in;
         ph1000_ff   <= ph1000_in;
         ph500_ff    <= ph500_in;
         ph200_ff    <= ph200_in;
         finished_ff <= finished_in;
      end
   end

   assign state.pattern  = pattern_ff;
   assign state.elapsed  = elapsed_ff;
   assign state.ph2000   = ph2000_ff;
   assign state.ph1000   = ph1000_ff;
   assign state.ph500    = ph500_ff;
   assign state.ph200    = ph200_ff;
   assign state.finished = finished_ff;

endmodule

// ----- design/rspg_render.sv -----
// Colour lookup for the current pattern state and the result register.
`timescale 1ns / 1ps

module rspg_render (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      state_valid,
   input  rspg_pkg::timer_state_type state,
   output logic                      done_now,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic                      rsp_done
);
   import rspg_pkg::*;

   logic [7:0]          red, green, blue;
   logic                finish_set;
   logic                double_on;
   logic [PH2000_W-1:0] tri_q;
   logic [PROD_W-1:0]   tri_prod;
   logic [7:0]          tri_level;
   logic                valid_ff;
   logic [7:0]          red_ff, green_ff, blue_ff;
   logic                done_ff;

   // Triangle wave: rising for the first half period, falling after it.
   always_comb begin
      tri_q = (state.ph2000 < PH2000_W'(BREATHE_HALF))
            ? state.ph2000
            : PH2000_W'(BREATHE_PERIOD) - state.ph2000;
      tri_prod  = PROD_W'(tri_q) * PROD_W'(BREATHE_RECIP);
      tri_level = tri_prod[RECIP_SHIFT +: 8];
   end

   // Two 80 ms flashes separated by 80 ms.
   assign double_on = (state.elapsed < 32'd80) ||
                      ((state.elapsed >= 32'd160) && (state.elapsed < 32'd240));

   // Colour and done condition for each pattern.
   always_comb begin
      red        = '0;
      green      = '0;
      blue       = '0;
      finish_set = 1'b0;
      case (state.pattern)
         PAT_SOLID_RED:   red = LEVEL_FULL;
         PAT_SOLID_GREEN: green = LEVEL_FULL;
         PAT_SOLID_BLUE:  blue = LEVEL_FULL;
         PAT_SOLID_AMBER: begin
            red   = LEVEL_FULL;
            green = AMBER_GREEN;
         end
         PAT_FLASH_GREEN: begin
            if (double_on) begin
               green = LEVEL_FULL;
            end else if (state.elapsed >= 32'd320) begin
               finish_set = 1'b1;
            end
         end
         PAT_FLASH_RED_SLOW: begin
            if (state.ph1000 < PH1000_W'(SLOW_PERIOD / 2)) red = LEVEL_FULL;
         end
         PAT_FLASH_RED_FAST: begin
            if (state.ph200 < PH200_W'(FAST_PERIOD / 2)) red = LEVEL_FULL;
         end
         PAT_FLASH_AMBER: begin
            if (state.ph500 < PH500_W'(AMBER_PERIOD / 2)) begin
               red   = LEVEL_FULL;
               green = AMBER_GREEN;
            end
         end
         PAT_FLASH_AMBER_DBL: begin
            if (double_on) begin
               red   = LEVEL_FULL;
               green = AMBER_GREEN;
            end else if (state.elapsed >= 32'd640) begin
               finish_set = 1'b1;
            end
         end
         PAT_BREATHE_RED:  red = tri_level;
         PAT_BREATHE_BLUE: blue = tri_level;
         PAT_RAINBOW: begin
            if (state.elapsed < 32'd400) begin
               red = LEVEL_FULL;
            end else if (state.elapsed < 32'd800) begin
               green = LEVEL_FULL;
            end else if (state.elapsed < 32'd1200) begin
               blue = LEVEL_FULL;
            end else if (state.elapsed < 32'd1600) begin
               red   = LEVEL_FULL;
               green = LEVEL_FULL;
               blue  = LEVEL_FULL;
            end else begin
               finish_set = 1'b1;
            end
         end
         PAT_FLASH_WHITE: begin
            if (state.elapsed < 32'd150) begin
               red   = LEVEL_FULL;
               green = LEVEL_FULL;
               blue  = LEVEL_FULL;
            end else begin
               finish_set = 1'b1;
            end
         end
         PAT_SUCCESS: begin
            if (state.elapsed < 32'd1000) begin
               green = LEVEL_FULL;
            end else begin
               finish_set = 1'b1;
            end
         end
         default: finish_set = 1'b1;
      endcase
   end

   assign done_now = state.finished | finish_set;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= state_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && state_valid) begin
         red_ff   <= red;
         green_ff <= green;
         blue_ff  <= blue;
         done_ff  <= done_now;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;
   assign rsp_done  = done_ff;

endmodule
